// File: src/counter_priority_task_scheduler_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the task scheduler
// Concurrent checks, with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef COUNTER_PRIORITY_TASK_SCHEDULER_UNIT_MACROS_SVH
`define COUNTER_PRIORITY_TASK_SCHEDULER_UNIT_MACROS_SVH

// check that is switched off while reset is high
`define CPTS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also runs through reset
`define CPTS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/cpts_pkg.sv
// ----------------------------------------------------------------------------
// cpts_pkg
// Types, codes and helpers shared by the task scheduler modules.
// ----------------------------------------------------------------------------
package cpts_pkg;

   localparam int MAX_TASKS    = 64;
   localparam int COUNTER_BITS = 16;
   localparam int SLOT_W       = $clog2(MAX_TASKS);
   localparam int IDX_W        = SLOT_W + 1;
   localparam int PRIO_W       = 7;
   localparam int DEPTH_W      = 8;
   localparam int RUN_W        = 2;
   localparam int KIND_W       = 3;
   localparam int RSP_CNT_W    = 16;
   // headroom for decrement, halve-and-add and loads
   localparam int EXT_W        = COUNTER_BITS + 9;

   localparam logic [KIND_W-1:0] KIND_TICK     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_YIELD    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_EXIT     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PDISABLE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_PENABLE  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_LOAD     = 3'd5;

   localparam logic [RUN_W-1:0] ST_UNUSED  = 2'd0;
   localparam logic [RUN_W-1:0] ST_RUNNING = 2'd1;
   localparam logic [RUN_W-1:0] ST_ZOMBIE  = 2'd2;

   localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

   typedef struct packed {
      logic [2:0] kind;
      logic [5:0] slot;
      logic [6:0] load_priority;
      logic [7:0] load_counter;
      logic [1:0] load_run_state;
   } req_type;

   typedef struct packed {
      logic [5:0]        current_slot;
      logic              switched;
      logic              recomputed;
      logic signed [15:0] current_counter;
   } rsp_type;

   typedef struct packed {
      logic signed [COUNTER_BITS-1:0] counter;
      logic [PRIO_W-1:0]              prio;
      logic [RUN_W-1:0]               run_state;
      logic [DEPTH_W-1:0]             depth;
   } entry_type;

   typedef struct packed {
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      entry_type         wr_data;
   } mem_req_type;

   // clamp a widened value into the signed counter range
   function automatic logic signed [COUNTER_BITS-1:0] cnt_sat(
      input logic signed [EXT_W-1:0] v);
      logic signed [EXT_W-1:0] hi;
      logic signed [EXT_W-1:0] lo;
      hi = {{(EXT_W-COUNTER_BITS+1){1'b0}}, {(COUNTER_BITS-1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         return hi[COUNTER_BITS-1:0];
      end else if (v < lo) begin
         return lo[COUNTER_BITS-1:0];
      end else begin
         return v[COUNTER_BITS-1:0];
      end
   endfunction

   function automatic logic signed [EXT_W-1:0] cnt_ext(
      input logic signed [COUNTER_BITS-1:0] c);
      return $signed({{(EXT_W-COUNTER_BITS){c[COUNTER_BITS-1]}}, c});
   endfunction

endpackage

// File: src/cpts_task_mem.sv
// ----------------------------------------------------------------------------
// cpts_task_mem
// Task slot table: one synchronous memory, one read and one write port,
// registered read. Per-slot valid bits stand in for the reset contents.
// ----------------------------------------------------------------------------
module cpts_task_mem (
   input  logic                  clock,
   input  logic                  reset,
   input  cpts_pkg::mem_req_type mem_req,
   output cpts_pkg::entry_type   rd_data
);
   import cpts_pkg::*;

   entry_type             mem [MAX_TASKS];
   logic [MAX_TASKS-1:0]  valid_ff;
   entry_type             raw_ff;
   logic                  hit_ff;
   logic [SLOT_W-1:0]     addr_ff;
   entry_type             reset_entry;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         raw_ff  <= mem[mem_req.rd_addr];
         addr_ff <= mem_req.rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (mem_req.wr_en) begin
            valid_ff[mem_req.wr_addr] <= 1'b1;
         end
         if (mem_req.rd_en) begin
            hit_ff <= valid_ff[mem_req.rd_addr];
         end
      end
   end

   // an unwritten slot reads as its reset contents
   always_comb begin
      reset_entry.counter   = '0;
      reset_entry.prio      = PRIO_W'(1);
      reset_entry.run_state = (addr_ff == '0) ? ST_RUNNING : ST_UNUSED;
      reset_entry.depth     = '0;
      rd_data = hit_ff ? raw_ff : reset_entry;
   end

endmodule

// File: src/cpts_ctrl.sv
// ----------------------------------------------------------------------------
// cpts_ctrl
// Event sequencer: read-modify-write of the current slot (a load writes
// its slot), then for schedules the slot-table scan, optional refill and rescan.
// ----------------------------------------------------------------------------
module cpts_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cpts_pkg::req_type     req,
   output cpts_pkg::mem_req_type mem_req,
   input  cpts_pkg::entry_type   rd_data,
   output logic                  res_valid,
   input  logic                  res_take,
   output cpts_pkg::rsp_type     result
);
   import cpts_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MOD    = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_REFILL = 3'd3;
   localparam logic [2:0] S_FINAL  = 3'd4;
   localparam logic [2:0] S_RESP   = 3'd5;
   localparam logic [2:0] S_OUT    = 3'd6;

   localparam logic signed [EXT_W-1:0] ONE_X  = EXT_W'(1);
   localparam logic signed [EXT_W-1:0] OUT_HI = EXT_W'(32767);
   localparam logic signed [EXT_W-1:0] OUT_LO = ~OUT_HI;
   localparam logic [IDX_W-1:0]        IDX_END = IDX_W'(MAX_TASKS);

   logic [2:0]                     state_ff, state_in;
   req_type                        req_ff, req_in;
   logic [SLOT_W-1:0]              cur_ff, cur_in;
   logic [SLOT_W-1:0]              prev_ff, prev_in;
   logic                           refilled_ff, refilled_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic                           pend_ff, pend_in;
   logic [SLOT_W-1:0]              pend_idx_ff, pend_idx_in;
   logic signed [COUNTER_BITS-1:0] best_ff, best_in;
   logic [SLOT_W-1:0]              best_slot_ff, best_slot_in;
   logic                           found_ff, found_in;
   logic signed [COUNTER_BITS-1:0] cnt_out_ff, cnt_out_in;

   logic                           accept;
   logic                           issue;
   logic                           last;
   logic                           cand;
   logic signed [EXT_W-1:0]        cur_x;
   logic signed [EXT_W-1:0]        dec_x;
   logic signed [COUNTER_BITS-1:0] dec_c;
   logic signed [COUNTER_BITS-1:0] load_c;
   logic signed [COUNTER_BITS-1:0] refill_c;
   logic                           slot_ok;
   logic                           sched;
   entry_type                      mod_e;
   logic signed [EXT_W-1:0]        out_x;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign res_valid = (state_ff == S_OUT);
   assign issue     = (idx_ff < IDX_END);
   assign last      = pend_ff && (idx_ff == IDX_END);

   // datapath values for the current entry and the sweeps
   always_comb begin
      cur_x    = cnt_ext(rd_data.counter);
      dec_x    = cur_x - ONE_X;
      dec_c    = cnt_sat(dec_x);
      load_c   = cnt_sat($signed({{(EXT_W-8){1'b0}}, req_ff.load_counter}));
      refill_c = cnt_sat((cur_x >>> 1)
                         + $signed({{(EXT_W-PRIO_W){1'b0}}, rd_data.prio}));
      slot_ok  = (int'(req_ff.slot) < MAX_TASKS);
      cand     = pend_ff && (rd_data.run_state == ST_RUNNING)
                 && (rd_data.counter > best_ff);
      out_x    = cnt_ext(cnt_out_ff);
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      refilled_in  = refilled_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      best_in      = best_ff;
      best_slot_in = best_slot_ff;
      found_in     = found_ff;
      cnt_out_in   = cnt_out_ff;
      sched        = 1'b0;
      mod_e        = rd_data;

      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = cur_ff;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = cur_ff;
      mem_req.wr_data = rd_data;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in        = req;
               prev_in       = cur_ff;
               refilled_in   = 1'b0;
               mem_req.rd_en = 1'b1;
               state_in      = S_MOD;
            end
         end
         S_MOD: begin
            cnt_out_in = rd_data.counter;
            case (req_ff.kind)
               KIND_TICK: begin
                  mem_req.wr_en = 1'b1;
                  if ((dec_c[COUNTER_BITS-1] || (dec_c == '0))
                      && (rd_data.depth == '0)) begin
                     mod_e.counter = '0;
                     sched = 1'b1;
                  end else begin
                     mod_e.counter = dec_c;
                  end
               end
               KIND_YIELD: begin
                  mem_req.wr_en = 1'b1;
                  mod_e.counter = '0;
                  sched = 1'b1;
               end
               KIND_EXIT: begin
                  mem_req.wr_en   = 1'b1;
                  mod_e.counter   = '0;
                  mod_e.run_state = ST_ZOMBIE;
                  sched = 1'b1;
               end
               KIND_PDISABLE: begin
                  mem_req.wr_en = 1'b1;
                  if (rd_data.depth != DEPTH_MAX) begin
                     mod_e.depth = rd_data.depth + DEPTH_W'(1);
                  end
               end
               KIND_PENABLE: begin
                  mem_req.wr_en = 1'b1;
                  if (rd_data.depth != '0) begin
                     mod_e.depth = rd_data.depth - DEPTH_W'(1);
                  end
               end
               KIND_LOAD: begin
                  mem_req.wr_en   = slot_ok;
                  mem_req.wr_addr = SLOT_W'(req_ff.slot);
                  mod_e.counter   = load_c;
                  mod_e.prio      = req_ff.load_priority;
                  mod_e.run_state = req_ff.load_run_state;
                  mod_e.depth     = '0;
                  if (slot_ok && (SLOT_W'(req_ff.slot) == cur_ff)) begin
                     cnt_out_in = load_c;
                  end
               end
               default: begin
               end
            endcase
            mem_req.wr_data = mod_e;
            if (req_ff.kind != KIND_LOAD) begin
               cnt_out_in = mod_e.counter;
            end
            if (sched) begin
               idx_in       = '0;
               pend_in      = 1'b0;
               best_in      = '1;
               best_slot_in = '0;
               found_in     = 1'b0;
               state_in     = S_SCAN;
            end else begin
               state_in = S_OUT;
            end
         end
         S_SCAN: begin
            mem_req.rd_en   = issue;
            mem_req.rd_addr = idx_ff[SLOT_W-1:0];
            if (issue) begin
               idx_in = idx_ff + IDX_W'(1);
            end
            pend_in     = issue;
            pend_idx_in = idx_ff[SLOT_W-1:0];
            if (cand) begin
               best_in      = rd_data.counter;
               best_slot_in = pend_idx_ff;
               found_in     = 1'b1;
            end
            if (last) begin
               if (found_in && (best_in == '0) && !refilled_ff) begin
                  refilled_in = 1'b1;
                  idx_in      = '0;
                  pend_in     = 1'b0;
                  state_in    = S_REFILL;
               end else begin
                  cur_in   = found_in ? best_slot_in : '0;
                  state_in = S_FINAL;
               end
            end
         end
         S_REFILL: begin
            // read slot i while slot i-1 is written back
            mem_req.rd_en   = issue;
            mem_req.rd_addr = idx_ff[SLOT_W-1:0];
            if (issue) begin
               idx_in = idx_ff + IDX_W'(1);
            end
            pend_in     = issue;
            pend_idx_in = idx_ff[SLOT_W-1:0];
            mod_e.counter   = refill_c;
            mem_req.wr_en   = pend_ff;
            mem_req.wr_addr = pend_idx_ff;
            mem_req.wr_data = mod_e;
            if (last) begin
               idx_in       = '0;
               pend_in      = 1'b0;
               best_in      = '1;
               best_slot_in = '0;
               found_in     = 1'b0;
               state_in     = S_SCAN;
            end
         end
         S_FINAL: begin
            mem_req.rd_en = 1'b1;
            state_in      = S_RESP;
         end
         S_RESP: begin
            cnt_out_in = rd_data.counter;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      result.current_slot = 6'(cur_ff);
      result.switched     = (cur_ff != prev_ff);
      result.recomputed   = refilled_ff;
      if (out_x > OUT_HI) begin
         result.current_counter = OUT_HI[RSP_CNT_W-1:0];
      end else if (out_x < OUT_LO) begin
         result.current_counter = OUT_LO[RSP_CNT_W-1:0];
      end else begin
         result.current_counter = out_x[RSP_CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cur_ff      <= '0;
         prev_ff     <= '0;
         refilled_ff <= 1'b0;
         idx_ff      <= '0;
         pend_ff     <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cur_ff      <= cur_in;
         prev_ff     <= prev_in;
         refilled_ff <= refilled_in;
         idx_ff      <= idx_in;
         pend_ff     <= pend_in;
         found_ff    <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      pend_idx_ff  <= pend_idx_in;
      best_ff      <= best_in;
      best_slot_ff <= best_slot_in;
      cnt_out_ff   <= cnt_out_in;
   end

endmodule

// File: src/counter_priority_task_scheduler_unit.sv
// Load, preempt, unknown and plain tick events pass from transfer through the slot
// read, the read-modify-write and the result state to the output register. Schedules
// (tick to zero, yield, exit) add a scan of all MAX_TASKS slots, with a refill also a
// refill pass and a rescan, then a read of the chosen slot, at one slot-table memory
// read per cycle. One event in flight: no new transfer until its result is taken.
// Reset is synchronous; slot contents return to defaults at once.
// ----------------------------------------------------------------------------
// counter_priority_task_scheduler_unit
// Counter/priority task scheduler over a memory of task slots.
// ----------------------------------------------------------------------------
module counter_priority_task_scheduler_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cpts_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cpts_pkg::rsp_type rsp
);
   import cpts_pkg::*;

   mem_req_type mem_req;
   entry_type   rd_data;
   logic        res_valid;
   logic        res_take;
   rsp_type     result;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   cpts_task_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   cpts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .mem_req   (mem_req),
      .rd_data   (rd_data),
      .res_valid (res_valid),
      .res_take  (res_take),
      .result    (result)
   );

   // output register: loads when empty or being drained this cycle
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: src/cpts_checker.sv
// ----------------------------------------------------------------------------
// cpts_checker
// Port-level checks on the task scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "counter_priority_task_scheduler_unit_macros.svh"

module cpts_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input cpts_pkg::rsp_type rsp
);
   import cpts_pkg::*;

   // one event at a time: a transfer closes the request side
   `CPTS_ASSERT(a_busy_after_req, clock, reset, (req_valid && !req_stall) |=> req_stall, "request taken while busy")
   // reset leaves the block idle and empty
   `CPTS_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!rsp_valid && !req_stall), "not idle after reset")
   `CPTS_ASSERT(a_rsp_hold_valid, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid, "result dropped while stalled")
   `CPTS_ASSERT(a_rsp_hold_data, clock, reset, (rsp_valid && rsp_stall) |=> $stable(rsp), "result changed while stalled")

endmodule

bind counter_priority_task_scheduler_unit cpts_checker u_cpts_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

// File: dv/tb_counter_priority_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// tb_counter_priority_task_scheduler_unit
// Self-checking bench for the task scheduler. Events are driven over the
// request channel. Each accepted event is run through a local scheduler
// model and the expected result is queued. Every response transfer is checked
// field by field against the oldest queued result. The traffic is a directed
// list, a preemption depth saturation run, receiver back-pressure and random
// event mixes under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module tb_counter_priority_task_scheduler_unit;
   import cpts_pkg::*;

   // kinds and run state outside the normal set
   localparam logic [KIND_W-1:0] KIND_RSVD6 = 3'd6;
   localparam logic [KIND_W-1:0] KIND_RSVD7 = 3'd7;
   localparam logic [RUN_W-1:0]  ST_RSVD    = 2'd3;

   localparam int HOLD_LEN   = 300;
   localparam int SETTLE_CYC = 250;
   localparam int MAX_REPORT = 10;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req       = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   // scheduler model state
   logic signed [COUNTER_BITS-1:0] slot_count [MAX_TASKS];
   logic [PRIO_W-1:0]              slot_prio  [MAX_TASKS];
   logic [RUN_W-1:0]               slot_state [MAX_TASKS];
   logic [DEPTH_W-1:0]             slot_depth [MAX_TASKS];
   logic [SLOT_W-1:0]              running_slot;

   rsp_type pending_rsp_q [$];
   rsp_type want;
   int      mismatch_count = 0;
   int      send_idle_pct  = 0;
   int      rcv_idle_pct   = 0;
   int      hold_req_cnt   = 0;
   int      hold_seen      = 0;
   int      hold_left      = 0;

   counter_priority_task_scheduler_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   // ------------------------------------------------------------------------
   // scheduler model
   // ------------------------------------------------------------------------
   function automatic logic signed [COUNTER_BITS-1:0] clamp_slice(input int v);
      int hi;
      int lo;
      hi = (1 << (COUNTER_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         return hi[COUNTER_BITS-1:0];
      end else if (v < lo) begin
         return lo[COUNTER_BITS-1:0];
      end
      return v[COUNTER_BITS-1:0];
   endfunction

   function automatic void clear_slots();
      for (int i = 0; i < MAX_TASKS; i++) begin
         slot_count[i] = '0;
         slot_prio[i]  = 7'd1;
         slot_state[i] = ST_UNUSED;
         slot_depth[i] = '0;
      end
      slot_state[0] = ST_RUNNING;
      running_slot  = '0;
   endfunction

   // highest non-negative counter among running slots, lowest slot on a tie
   function automatic bit pick_runnable(output logic [SLOT_W-1:0] idx, output int best);
      bit found;
      found = 1'b0;
      best  = -1;
      idx   = '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
         if (slot_state[i] == ST_RUNNING && int'(slot_count[i]) > best) begin
            best  = int'(slot_count[i]);
            idx   = i[SLOT_W-1:0];
            found = 1'b1;
         end
      end
      return found;
   endfunction

   function automatic bit schedule_next();
      logic [SLOT_W-1:0] pick;
      int                best;
      bit                found;
      bit                refilled;
      refilled = 1'b0;
      found    = pick_runnable(pick, best);
      if (found && best == 0) begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            // arithmetic shift gives floor halving for negative counters
            slot_count[i] = clamp_slice((int'(slot_count[i]) >>> 1) + int'(slot_prio[i]));
         end
         refilled = 1'b1;
         found    = pick_runnable(pick, best);
      end
      running_slot = found ? pick : '0;
      return refilled;
   endfunction

   function automatic rsp_type predict_schedule(input req_type ev);
      rsp_type           res;
      logic [SLOT_W-1:0] prev;
      bit                refilled;
      prev     = running_slot;
      refilled = 1'b0;
      case (ev.kind)
         KIND_TICK: begin
            slot_count[running_slot] = clamp_slice(int'(slot_count[running_slot]) - 1);
            if (int'(slot_count[running_slot]) <= 0 && slot_depth[running_slot] == 0) begin
               slot_count[running_slot] = '0;
               refilled = schedule_next();
            end
         end
         KIND_YIELD: begin
            slot_count[running_slot] = '0;
            refilled = schedule_next();
         end
         KIND_EXIT: begin
            slot_state[running_slot] = ST_ZOMBIE;
            slot_count[running_slot] = '0;
            refilled = schedule_next();
         end
         KIND_PDISABLE: begin
            if (slot_depth[running_slot] != DEPTH_MAX) begin
               slot_depth[running_slot] = slot_depth[running_slot] + 1'b1;
            end
         end
         KIND_PENABLE: begin
            if (slot_depth[running_slot] != '0) begin
               slot_depth[running_slot] = slot_depth[running_slot] - 1'b1;
            end
         end
         KIND_LOAD: begin
            slot_prio[ev.slot]  = ev.load_priority;
            slot_count[ev.slot] = clamp_slice(int'(ev.load_counter));
            slot_state[ev.slot] = ev.load_run_state;
            slot_depth[ev.slot] = '0;
         end
         default: ;
      endcase
      res.current_slot    = running_slot;
      res.switched        = (running_slot != prev);
      res.recomputed      = refilled;
      res.current_counter = slot_count[running_slot];
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   function automatic req_type make_event(input logic [KIND_W-1:0] kind,
                                          input logic [5:0] slot,
                                          input logic [6:0] prio,
                                          input logic [7:0] cnt,
                                          input logic [1:0] st);
      req_type ev;
      ev.kind           = kind;
      ev.slot           = slot;
      ev.load_priority  = prio;
      ev.load_counter   = cnt;
      ev.load_run_state = st;
      return ev;
   endfunction

   function automatic req_type rand_sched_event();
      req_type ev;
      int      pct;
      ev.slot           = 6'($urandom_range(63));
      ev.load_priority  = 7'($urandom_range(127, 1));
      ev.load_counter   = 8'($urandom_range(254));
      ev.load_run_state = 2'($urandom_range(2));
      pct = $urandom_range(99);
      if (pct < 28) begin
         ev.kind = KIND_LOAD;
         // keep most loads on a few slots with short slices so schedules bite
         if ($urandom_range(99) < 70) ev.slot = 6'($urandom_range(7));
         if ($urandom_range(99) < 60) ev.load_counter = 8'($urandom_range(6));
         if ($urandom_range(99) < 40) ev.load_priority = 7'($urandom_range(4, 1));
         if ($urandom_range(99) < 60) ev.load_run_state = ST_RUNNING;
      end else if (pct < 63) begin
         ev.kind = KIND_TICK;
      end else if (pct < 76) begin
         ev.kind = KIND_YIELD;
      end else if (pct < 82) begin
         ev.kind = KIND_EXIT;
      end else if (pct < 91) begin
         ev.kind = KIND_PDISABLE;
      end else begin
         ev.kind = KIND_PENABLE;
      end
      return ev;
   endfunction

   task automatic send_event(input req_type ev);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= ev;
      do @(posedge clock); while (req_stall);
      pending_rsp_q.push_back(predict_schedule(ev));
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // response check
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORT) begin
               $display("unexpected result: slot %0d sw %0b rc %0b cnt %0d",
                        rsp.current_slot, rsp.switched, rsp.recomputed,
                        rsp.current_counter);
            end
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp.current_slot !== want.current_slot || rsp.switched !== want.switched ||
                rsp.recomputed !== want.recomputed ||
                rsp.current_counter !== want.current_counter) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORT) begin
                  $display({"mismatch: exp slot %0d sw %0b rc %0b cnt %0d, ",
                            "got slot %0d sw %0b rc %0b cnt %0d"},
                           want.current_slot, want.switched, want.recomputed,
                           want.current_counter, rsp.current_slot, rsp.switched,
                           rsp.recomputed, rsp.current_counter);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // receiver stall
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      // a new hold-off request restarts the long stall
      if (hold_req_cnt != hold_seen) begin
         hold_seen = hold_req_cnt;
         hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_directed();
      send_event(make_event(KIND_TICK, 0, 0, 0, 0));        // refill from reset state
      send_event(make_event(KIND_LOAD, 63, 127, 254, ST_RUNNING));
      send_event(make_event(KIND_LOAD, 1, 1, 0, ST_RSVD));
      send_event(make_event(KIND_LOAD, 2, 64, 0, ST_ZOMBIE));
      send_event(make_event(KIND_YIELD, 0, 0, 0, 0));
      send_event(make_event(KIND_PDISABLE, 0, 0, 0, 0));
      send_event(make_event(KIND_TICK, 0, 0, 0, 0));
      send_event(make_event(KIND_TICK, 0, 0, 0, 0));
      send_event(make_event(KIND_PENABLE, 0, 0, 0, 0));
      send_event(make_event(KIND_PENABLE, 0, 0, 0, 0));     // already at zero
      send_event(make_event(KIND_RSVD6, 0, 0, 0, 0));
      send_event(make_event(KIND_RSVD7, 63, 127, 255, 3));
      send_event(make_event(KIND_EXIT, 0, 0, 0, 0));
      // nothing left running: falls back to slot 0
      send_event(make_event(KIND_LOAD, 0, 1, 5, ST_UNUSED));
      send_event(make_event(KIND_YIELD, 0, 0, 0, 0));
      send_event(make_event(KIND_TICK, 0, 0, 0, 0));
      // zero priority: refill leaves the best counter at zero
      send_event(make_event(KIND_LOAD, 7, 0, 0, ST_RUNNING));
      send_event(make_event(KIND_YIELD, 0, 0, 0, 0));
      // equal counters: lowest slot wins
      send_event(make_event(KIND_LOAD, 9, 5, 200, ST_RUNNING));
      send_event(make_event(KIND_LOAD, 8, 5, 200, ST_RUNNING));
      send_event(make_event(KIND_YIELD, 0, 0, 0, 0));
      send_event(make_event(KIND_EXIT, 0, 0, 0, 0));
      wait_all_results();
   endtask

   task automatic test_preempt_saturation();
      send_event(make_event(KIND_LOAD, 3, 9, 2, ST_RUNNING));
      send_event(make_event(KIND_YIELD, 0, 0, 0, 0));
      repeat (257) send_event(make_event(KIND_PDISABLE, 0, 0, 0, 0));
      // counter runs negative while preemption is held off
      repeat (6) send_event(make_event(KIND_TICK, 0, 0, 0, 0));
      repeat (257) send_event(make_event(KIND_PENABLE, 0, 0, 0, 0));
      send_event(make_event(KIND_TICK, 0, 0, 0, 0));
      wait_all_results();
   endtask

   task automatic test_backpressure();
      int saved_idle;
      saved_idle    = send_idle_pct;
      send_idle_pct = 0;
      hold_req_cnt++;
      repeat (12) send_event(rand_sched_event());
      send_idle_pct = saved_idle;
      wait_all_results();
   endtask

   task automatic test_random_traffic(input int n, input int snd_pct, input int rcv_pct);
      send_idle_pct = snd_pct;
      rcv_idle_pct  = rcv_pct;
      repeat (n) send_event(rand_sched_event());
      wait_all_results();
   endtask

   initial begin
      clear_slots();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 36;
      rcv_idle_pct  = 51;
      test_directed();
      test_preempt_saturation();
      test_random_traffic(400, 36, 51);
      test_random_traffic(400, 51, 36);
      test_backpressure();
      test_random_traffic(400, 0, 0);

      wait_all_results();
      repeat (SETTLE_CYC) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/cpts_pkg.sv
src/cpts_task_mem.sv
src/cpts_ctrl.sv
src/counter_priority_task_scheduler_unit.sv
src/cpts_checker.sv
dv/tb_counter_priority_task_scheduler_unit.sv
